// ===== sv/pps_lock_detector_core_defines.svh =====
// Assertion macros used by the lock detector core.
`ifndef PPS_LOCK_DETECTOR_CORE_DEFINES_SVH
`define PPS_LOCK_DETECTOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PLD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PLD_ASSERT_IMPL(label, ante, cons)
`define PLD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/pld_pkg.sv =====
// Types and constants of the lock detector.
package pld_pkg;

  localparam int RING_DEPTH = 10;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = 16 + $clog2(RING_DEPTH);
  localparam int PADDR_W    = 5;
  localparam int OUT_W      = 56;

  localparam logic [15:0] DEFAULT_PERIOD       = 16'd1000;
  localparam logic [15:0] MIN_PERIOD_RST       = 16'd100;
  localparam logic [15:0] MAX_PERIOD_RST       = 16'd5000;
  localparam logic [15:0] JITTER_LIMIT_RST     = 16'd10;
  localparam logic [15:0] SYNC_TIMEOUT_RST     = 16'd5000;
  localparam logic [15:0] HOLDOVER_TIMEOUT_RST = 16'd17500;

  localparam logic KIND_PULSE = 1'b0;

  typedef enum logic [2:0] {
    REG_MIN_PERIOD       = 3'd0,
    REG_MAX_PERIOD       = 3'd1,
    REG_JITTER_LIMIT     = 3'd2,
    REG_SYNC_TIMEOUT     = 3'd3,
    REG_HOLDOVER_TIMEOUT = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    STAGE_SEARCH = 2'd0,
    STAGE_CHECK  = 2'd1,
    STAGE_LOCK   = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] abs_sum;
    logic [SUM_W-1:0] tot_sum;
  } walk_res_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] jitter;
    logic [15:0]      mean;
  } div_res_t;

endpackage

// ===== sv/pps_lock_detector_core.sv =====
// Lock detector for a pulse-per-second reference: control, state and ring memory.
//
// The input stream carries one event per word: tuser holds the kind (pulse or
// timeout check) and tdata the 32-bit millisecond time. Each event gives exactly
// one result word on the output stream with the stage, the accept flag, the
// saturated interval, the mean interval difference and the held period.
// Registers are set through the APB port; pready is always high.
// An event that needs no ring walk (a check, a rejected pulse or a pulse taken
// while searching that does not fill the ring) passes through the done state
// into the output register, and the input is ready again as the result is loaded.
// An accepted pulse that fills the ring while searching or comes while checking
// or locked walks the whole interval ring through the memory read port, one
// entry a cycle, then runs two divider stages; its result then passes through
// the done state into the output register, and the next word is taken when the
// result is loaded. The walk uses the single read port of the ring memory.
// The input is taken again once the result sits in the output register, so the
// next event is worked on while an earlier result waits. If the receiver stalls,
// the finished result of the following event waits inside until the register frees.
// Reset loads the register defaults, empties the ring (all entries read as zero)
// and sets the stage to searching with the default period of 1000 ms.
`include "pps_lock_detector_core_defines.svh"
module pps_lock_detector_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // [31:0] time_now
  input  logic [0:0]                  s_axis_tuser,  // [0] kind
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [1:0] stage, [2] accepted, [18:3] last_interval, [34:19] jitter_mean,
  // [50:35] avg_period, [51] period_valid, [55:52] zero
  output logic [pld_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pld_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import pld_pkg::*;

  fsm_e             state_q, state_d;
  stage_e           stage_q, stage_d, stage_wr;
  logic [IDX_W-1:0] pos_q, pos_d, pos_wrap;
  logic [31:0]      prev_time_q, prev_time_d;
  logic [15:0]      held_q, held_d;
  logic             held_valid_q, held_valid_d;
  logic [15:0]      jitter_q, jitter_d;
  logic             acc_q, acc_d;
  logic [15:0]      shown_q, shown_d;
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic             rd_vld_q;

  logic [15:0] min_period_q, max_period_q, jitter_limit_q, sync_timeout_q, holdover_timeout_q;

  logic        in_fire, is_pulse, in_range, pos_last, ram_we, walk_start, out_free, lock_now;
  logic [31:0] elapsed;
  logic [15:0] ram_q, rd_data;
  logic        cfg_we;
  reg_idx_e    cfg_idx;
  rd_req_t     rd_req;
  walk_res_t   walk_res;
  div_res_t    div_res;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q       <= MIN_PERIOD_RST;
      max_period_q       <= MAX_PERIOD_RST;
      jitter_limit_q     <= JITTER_LIMIT_RST;
      sync_timeout_q     <= SYNC_TIMEOUT_RST;
      holdover_timeout_q <= HOLDOVER_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MIN_PERIOD:       min_period_q       <= pwdata[15:0];
        REG_MAX_PERIOD:       max_period_q       <= pwdata[15:0];
        REG_JITTER_LIMIT:     jitter_limit_q     <= pwdata[15:0];
        REG_SYNC_TIMEOUT:     sync_timeout_q     <= pwdata[15:0];
        REG_HOLDOVER_TIMEOUT: holdover_timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_PERIOD:       prdata = {16'h0000, min_period_q};
      REG_MAX_PERIOD:       prdata = {16'h0000, max_period_q};
      REG_JITTER_LIMIT:     prdata = {16'h0000, jitter_limit_q};
      REG_SYNC_TIMEOUT:     prdata = {16'h0000, sync_timeout_q};
      REG_HOLDOVER_TIMEOUT: prdata = {16'h0000, holdover_timeout_q};
      default:              prdata = '0;
    endcase
  end

  // Event decode.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_pulse      = in_fire && (s_axis_tuser[0] == KIND_PULSE);
  assign elapsed       = s_axis_tdata - prev_time_q;
  assign in_range      = (elapsed >= {16'h0000, min_period_q}) &&
                         (elapsed <= {16'h0000, max_period_q});
  assign pos_last      = (pos_q == IDX_W'(RING_DEPTH - 1));
  assign pos_wrap      = pos_last ? '0 : pos_q + 1'b1;
  assign stage_wr      = (stage_q == STAGE_SEARCH && pos_last) ? STAGE_CHECK : stage_q;
  assign ram_we        = is_pulse && in_range;
  assign walk_start    = ram_we && (stage_wr != STAGE_SEARCH);
  assign out_free      = !out_valid_q || m_axis_tready;

  // Ring memory; an entry never written reads as zero.
  pld_ram #(
    .WIDTH (16),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (elapsed[15:0]),
    .re_i    (rd_req.en),
    .raddr_i (rd_req.addr),
    .rdata_o (ram_q)
  );

  assign rd_data = rd_vld_q ? ram_q : '0;

  pld_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (walk_start),
    .start_idx_i (pos_wrap),
    .rd_data_i   (rd_data),
    .rd_req_o    (rd_req),
    .res_o       (walk_res)
  );

  pld_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (walk_res.done),
    .abs_sum_i (walk_res.abs_sum),
    .tot_sum_i (walk_res.tot_sum),
    .res_o     (div_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = walk_start ? ST_WALK : ST_DONE;
      ST_WALK: if (walk_res.done) state_d = ST_DIV;
      ST_DIV:  if (div_res.done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
    endcase
  end

  // The mean difference never exceeds 65535, so its low half is the saturated value.
  assign lock_now = (stage_q == STAGE_LOCK) ||
                    (stage_q == STAGE_CHECK && div_res.jitter <= SUM_W'(jitter_limit_q));

  // State updates and result register.
  always_comb begin
    stage_d      = stage_q;
    pos_d        = pos_q;
    prev_time_d  = prev_time_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    jitter_d     = jitter_q;
    acc_d        = acc_q;
    shown_d      = shown_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          acc_d   = 1'b0;
          shown_d = '0;
          if (is_pulse) begin
            prev_time_d = s_axis_tdata;
            shown_d     = (elapsed[31:16] != '0) ? 16'hFFFF : elapsed[15:0];
            if (in_range) begin
              acc_d   = 1'b1;
              pos_d   = pos_wrap;
              stage_d = stage_wr;
            end else begin
              pos_d = '0;
            end
          end else begin
            if (elapsed > {16'h0000, sync_timeout_q}) begin
              stage_d = STAGE_SEARCH;
            end
            if (elapsed > {16'h0000, holdover_timeout_q}) begin
              held_d       = DEFAULT_PERIOD;
              held_valid_d = 1'b0;
            end
          end
        end
      end
      ST_WALK: ;
      ST_DIV: begin
        if (div_res.done) begin
          if (stage_q == STAGE_CHECK) begin
            jitter_d = div_res.jitter[15:0];
          end
          if (lock_now) begin
            stage_d      = STAGE_LOCK;
            held_d       = div_res.mean;
            held_valid_d = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'h0, held_valid_q, held_q, jitter_q, shown_q, acc_q, stage_q};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      stage_q      <= STAGE_SEARCH;
      pos_q        <= '0;
      prev_time_q  <= '0;
      held_q       <= DEFAULT_PERIOD;
      held_valid_q <= 1'b0;
      jitter_q     <= '0;
      out_valid_q  <= 1'b0;
      ring_vld_q   <= '0;
      rd_vld_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      stage_q      <= stage_d;
      pos_q        <= pos_d;
      prev_time_q  <= prev_time_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      jitter_q     <= jitter_d;
      out_valid_q  <= out_valid_d;
      if (ram_we) begin
        ring_vld_q[pos_q] <= 1'b1;
      end
      if (rd_req.en) begin
        rd_vld_q <= ring_vld_q[rd_req.addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    shown_q    <= shown_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `PLD_ASSERT_IMPL(a_div_done_in_div, div_res.done, state_q == ST_DIV)
  `PLD_ASSERT_IMPL(a_no_write_during_walk, ram_we, !rd_req.en)
  `PLD_ASSERT_IMPL(a_held_valid_on_lock, $rose(held_valid_q), stage_q == STAGE_LOCK)

endmodule

// ===== sv/pld_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pld_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pld_walk.sv =====
// Ring walker: reads every ring entry from the oldest on and sums entries and differences.
module pld_walk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pld_pkg::IDX_W-1:0]  start_idx_i,
  input  logic [15:0]                rd_data_i,
  output pld_pkg::rd_req_t           rd_req_o,
  output pld_pkg::walk_res_t         res_o
);
  import pld_pkg::*;

  logic [IDX_W-1:0] addr_q, addr_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic             dv_q, dv_d;
  logic             last_q, last_d;
  logic             first_q, first_d;
  logic             done_q, done_d;
  logic [15:0]      prev_q, prev_d;
  logic [SUM_W-1:0] abs_q, abs_d;
  logic [SUM_W-1:0] tot_q, tot_d;
  logic             issue;
  logic [15:0]      diff;

  assign issue = (left_q != '0);
  assign diff  = (rd_data_i >= prev_q) ? (rd_data_i - prev_q) : (prev_q - rd_data_i);

  always_comb begin
    addr_d  = addr_q;
    left_d  = left_q;
    first_d = first_q;
    prev_d  = prev_q;
    abs_d   = abs_q;
    tot_d   = tot_q;
    dv_d    = issue;
    last_d  = issue && (left_q == CNT_W'(1));
    done_d  = dv_q && last_q;
    if (start_i) begin
      addr_d  = start_idx_i;
      left_d  = CNT_W'(RING_DEPTH);
      first_d = 1'b1;
      abs_d   = '0;
      tot_d   = '0;
    end else begin
      if (issue) begin
        addr_d = (addr_q == IDX_W'(RING_DEPTH - 1)) ? '0 : addr_q + 1'b1;
        left_d = left_q - 1'b1;
      end
      if (dv_q) begin
        tot_d   = tot_q + SUM_W'(rd_data_i);
        abs_d   = first_q ? abs_q : abs_q + SUM_W'(diff);
        prev_d  = rd_data_i;
        first_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      dv_q    <= 1'b0;
      last_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      left_q  <= left_d;
      dv_q    <= dv_d;
      last_q  <= last_d;
      first_q <= first_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    prev_q <= prev_d;
    abs_q  <= abs_d;
    tot_q  <= tot_d;
  end

  assign rd_req_o.en    = issue;
  assign rd_req_o.addr  = addr_q;
  assign res_o.done     = done_q;
  assign res_o.abs_sum  = abs_q;
  assign res_o.tot_sum  = tot_q;

endmodule

// ===== sv/pld_div.sv =====
// Two-stage constant dividers for the mean difference and the ring mean.
module pld_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pld_pkg::SUM_W-1:0] abs_sum_i,
  input  logic [pld_pkg::SUM_W-1:0] tot_sum_i,
  output pld_pkg::div_res_t         res_o
);
  import pld_pkg::*;

  localparam int PROD_W = 2 * SUM_W;
  localparam logic [SUM_W-1:0] DIV_J = SUM_W'(RING_DEPTH - 1);
  localparam logic [SUM_W-1:0] DIV_M = SUM_W'(RING_DEPTH);
  localparam logic [SUM_W-1:0] RCP_J = SUM_W'((2 ** SUM_W) / (RING_DEPTH - 1));
  localparam logic [SUM_W-1:0] RCP_M = SUM_W'((2 ** SUM_W) / RING_DEPTH);

  logic              v1_q, v2_q;
  logic [SUM_W-1:0]  abs1_q, tot1_q;
  logic [PROD_W-1:0] pj_q, pm_q;
  logic [SUM_W-1:0]  qj0, qm0, rj, rm, qj, qm;
  logic [SUM_W-1:0]  jit_q;
  logic [15:0]       mean_q;

  // The reciprocal estimate is low by at most one; one compare corrects it.
  always_comb begin
    qj0 = pj_q[PROD_W-1:SUM_W];
    qm0 = pm_q[PROD_W-1:SUM_W];
    rj  = abs1_q - SUM_W'(qj0 * DIV_J);
    rm  = tot1_q - SUM_W'(qm0 * DIV_M);
    qj  = (rj >= DIV_J) ? qj0 + 1'b1 : qj0;
    qm  = (rm >= DIV_M) ? qm0 + 1'b1 : qm0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    abs1_q <= abs_sum_i;
    tot1_q <= tot_sum_i;
    pj_q   <= PROD_W'(abs_sum_i) * PROD_W'(RCP_J);
    pm_q   <= PROD_W'(tot_sum_i) * PROD_W'(RCP_M);
    jit_q  <= qj;
    mean_q <= qm[15:0];
  end

  assign res_o.done   = v2_q;
  assign res_o.jitter = jit_q;
  assign res_o.mean   = mean_q;

endmodule

// ===== tb/sv/pps_lock_detector_core_tb.sv =====
// Self-checking testbench for the PPS lock detector core: directed and random event streams.
module pps_lock_detector_core_tb;
  import pld_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 5000;
  localparam int unsigned DRAIN_SLACK      = 24;
  localparam int unsigned RANDOM_PER_PHASE = 170;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam logic        KIND_CHECK       = 1'b1;
  localparam logic [2:0]  REG_FIRST_UNUSED = 3'd5;
  localparam logic [2:0]  REG_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    stage_e      stage;
    logic        accepted;
    logic [15:0] interval;
    logic [15:0] jitter;
    logic [15:0] avg;
    logic        valid;
  } pld_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;
  logic [0:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  logic [15:0] cfg_min_period;
  logic [15:0] cfg_max_period;
  logic [15:0] cfg_jitter_limit;
  logic [15:0] cfg_sync_timeout;
  logic [15:0] cfg_holdover_timeout;

  logic [15:0] interval_hist [RING_DEPTH];
  int unsigned hist_wr_pos;
  stage_e      lock_stage;
  logic [31:0] last_pulse_time;
  logic [15:0] held_period;
  logic        held_valid;
  logic [15:0] jitter_held;

  pld_result_t pending_results[$];
  pld_result_t result_want;
  int unsigned mismatch_count;
  int unsigned events_sent;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned quiet_cycles;

  pps_lock_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic reset_lock_state();
    cfg_min_period       = MIN_PERIOD_RST;
    cfg_max_period       = MAX_PERIOD_RST;
    cfg_jitter_limit     = JITTER_LIMIT_RST;
    cfg_sync_timeout     = SYNC_TIMEOUT_RST;
    cfg_holdover_timeout = HOLDOVER_TIMEOUT_RST;
    for (int k = 0; k < RING_DEPTH; k++) interval_hist[k] = 16'd0;
    hist_wr_pos     = 0;
    lock_stage      = STAGE_SEARCH;
    last_pulse_time = 32'd0;
    held_period     = DEFAULT_PERIOD;
    held_valid      = 1'b0;
    jitter_held     = 16'd0;
  endtask

  function automatic logic [31:0] interval_jitter(int unsigned start);
    logic [31:0] sum;
    logic [31:0] a;
    logic [31:0] b;
    sum = 32'd0;
    for (int unsigned k = 0; k + 1 < RING_DEPTH; k++) begin
      a = 32'(interval_hist[(start + k) % RING_DEPTH]);
      b = 32'(interval_hist[(start + k + 1) % RING_DEPTH]);
      sum += (a > b) ? (a - b) : (b - a);
    end
    return sum / (RING_DEPTH - 1);
  endfunction

  function automatic logic [15:0] interval_average();
    logic [31:0] sum;
    sum = 32'd0;
    for (int k = 0; k < RING_DEPTH; k++) sum += 32'(interval_hist[k]);
    return 16'(sum / RING_DEPTH);
  endfunction

  task automatic advance_lock_state(input logic kind, input logic [31:0] now,
                                    output pld_result_t res);
    logic [31:0] elapsed;
    logic [31:0] mean_diff;
    elapsed = now - last_pulse_time;
    res = '0;
    if (kind == KIND_PULSE) begin
      res.interval = (elapsed > 32'hFFFF) ? 16'hFFFF : elapsed[15:0];
      if (elapsed >= 32'(cfg_min_period) && elapsed <= 32'(cfg_max_period)) begin
        res.accepted = 1'b1;
        if (hist_wr_pos >= RING_DEPTH) hist_wr_pos = 0;
        interval_hist[hist_wr_pos] = elapsed[15:0];
        hist_wr_pos++;
        if (lock_stage == STAGE_SEARCH && hist_wr_pos == RING_DEPTH) lock_stage = STAGE_CHECK;
        if (lock_stage == STAGE_CHECK) begin
          mean_diff = interval_jitter(hist_wr_pos % RING_DEPTH);
          jitter_held = (mean_diff > 32'hFFFF) ? 16'hFFFF : mean_diff[15:0];
          if (mean_diff <= 32'(cfg_jitter_limit)) lock_stage = STAGE_LOCK;
        end
        if (lock_stage == STAGE_LOCK) begin
          held_period = interval_average();
          held_valid  = 1'b1;
        end
        if (hist_wr_pos >= RING_DEPTH) hist_wr_pos = 0;
      end else begin
        hist_wr_pos = 0;
      end
      last_pulse_time = now;
    end else begin
      if (elapsed > 32'(cfg_sync_timeout)) lock_stage = STAGE_SEARCH;
      if (elapsed > 32'(cfg_holdover_timeout)) begin
        held_period = DEFAULT_PERIOD;
        held_valid  = 1'b0;
      end
    end
    res.stage  = lock_stage;
    res.jitter = jitter_held;
    res.avg    = held_period;
    res.valid  = held_valid;
  endtask

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic send_event(logic kind, logic [31:0] now);
    int unsigned gap;
    pld_result_t res;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_lock_state(kind, now, res);
    pending_results.push_back(res);
    events_sent++;
  endtask

  task automatic send_pulse_after(logic [31:0] interval);
    send_event(KIND_PULSE, last_pulse_time + interval);
  endtask

  task automatic send_check_after(logic [31:0] elapsed);
    send_event(KIND_CHECK, last_pulse_time + elapsed);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MIN_PERIOD:       cfg_min_period       = value[15:0];
      REG_MAX_PERIOD:       cfg_max_period       = value[15:0];
      REG_JITTER_LIMIT:     cfg_jitter_limit     = value[15:0];
      REG_SYNC_TIMEOUT:     cfg_sync_timeout     = value[15:0];
      REG_HOLDOVER_TIMEOUT: cfg_holdover_timeout = value[15:0];
      default: ;
    endcase
  endtask

  task automatic reg_read_check(logic [2:0] idx, logic [15:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got[15:0] !== want) note_mismatch("register read", 32'(want), got);
  endtask

  task automatic check_registers();
    reg_read_check(REG_MIN_PERIOD, cfg_min_period);
    reg_read_check(REG_MAX_PERIOD, cfg_max_period);
    reg_read_check(REG_JITTER_LIMIT, cfg_jitter_limit);
    reg_read_check(REG_SYNC_TIMEOUT, cfg_sync_timeout);
    reg_read_check(REG_HOLDOVER_TIMEOUT, cfg_holdover_timeout);
  endtask

  task automatic configure(logic [15:0] min_p, logic [15:0] max_p, logic [15:0] jit,
                           logic [15:0] sync_to, logic [15:0] hold_to);
    drain();
    reg_write(REG_MIN_PERIOD, {16'($urandom()), min_p});
    reg_write(REG_MAX_PERIOD, {16'($urandom()), max_p});
    reg_write(REG_JITTER_LIMIT, {16'($urandom()), jit});
    reg_write(REG_SYNC_TIMEOUT, {16'($urandom()), sync_to});
    reg_write(REG_HOLDOVER_TIMEOUT, {16'($urandom()), hold_to});
    check_registers();
  endtask

  task automatic test_register_defaults();
    check_registers();
  endtask

  task automatic test_interval_bounds();
    send_event(KIND_PULSE, 32'd0);
    send_check_after(32'd0);
    send_pulse_after(32'(cfg_min_period) - 1);
    send_pulse_after(32'(cfg_min_period));
    send_pulse_after(32'(cfg_max_period));
    send_pulse_after(32'(cfg_max_period) + 1);
    send_pulse_after(32'd70000);
    send_pulse_after(32'hFFFF_FFFF);
    send_check_after(32'(cfg_holdover_timeout) + 1);
  endtask

  task automatic test_lock_and_holdover();
    repeat (10) send_pulse_after(32'd1000);
    send_pulse_after(32'd1013);
    send_pulse_after(32'd996);
    send_check_after(32'(cfg_sync_timeout));
    send_check_after(32'(cfg_sync_timeout) + 1);
    send_check_after(32'(cfg_holdover_timeout));
    send_check_after(32'(cfg_holdover_timeout) + 1);
  endtask

  task automatic test_register_extremes();
    configure(16'hFFFF, 16'h0000, JITTER_LIMIT_RST, SYNC_TIMEOUT_RST, HOLDOVER_TIMEOUT_RST);
    for (int i = REG_FIRST_UNUSED; i <= REG_LAST_UNUSED; i++) reg_write(3'(i), $urandom());
    check_registers();
    send_pulse_after(32'd0);
    send_pulse_after(32'd65535);
    configure(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_pulse_after(32'd0);
    send_check_after(32'd1);
  endtask

  task automatic test_random_traffic(int unsigned src_pct, int unsigned sink_pct,
                                     logic [15:0] min_p, logic [15:0] max_p, logic [15:0] jit,
                                     logic [15:0] sync_to, logic [15:0] hold_to);
    int unsigned first;
    int unsigned pick;
    int unsigned amp;
    int unsigned run_len;
    int lo;
    int hi;
    int nominal;
    int iv;
    configure(min_p, max_p, jit, sync_to, hold_to);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    lo = int'(cfg_min_period);
    hi = int'(cfg_max_period);
    first = events_sent;
    while (events_sent - first < RANDOM_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 65 && lo <= hi) begin
        nominal = int'($urandom_range(hi, lo));
        case ($urandom_range(3))
          0: amp = 0;
          1: amp = 1;
          2: amp = (cfg_jitter_limit > 16'd2000) ? 2000 : int'(cfg_jitter_limit);
          default: amp = $urandom_range(50);
        endcase
        run_len = $urandom_range(24, 6);
        repeat (run_len) begin
          if ($urandom_range(9) == 0) send_check_after($urandom_range(nominal));
          iv = nominal + int'($urandom_range(2 * amp)) - int'(amp);
          if (iv < lo) iv = lo;
          if (iv > hi) iv = hi;
          send_pulse_after(32'(iv));
        end
      end else if (pick < 80) begin
        case ($urandom_range(4))
          0: send_check_after(32'(cfg_sync_timeout));
          1: send_check_after(32'(cfg_sync_timeout) + 1);
          2: send_check_after(32'(cfg_holdover_timeout));
          3: send_check_after(32'(cfg_holdover_timeout) + 1);
          default: send_check_after($urandom());
        endcase
      end else begin
        case ($urandom_range(3))
          0: send_event(1'($urandom_range(1)), $urandom());
          1: send_pulse_after(32'(cfg_min_period) - 1);
          2: send_pulse_after(32'(cfg_max_period) + 1);
          default: send_pulse_after($urandom_range(2 * hi + 2));
        endcase
      end
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unpredicted result word", 32'd0, m_axis_tdata[31:0]);
      end else begin
        result_want = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== result_want.stage)
          note_mismatch("stage", 32'(result_want.stage), 32'(m_axis_tdata[1:0]));
        if (m_axis_tdata[2] !== result_want.accepted)
          note_mismatch("accepted", 32'(result_want.accepted), 32'(m_axis_tdata[2]));
        if (m_axis_tdata[18:3] !== result_want.interval)
          note_mismatch("last_interval", 32'(result_want.interval), 32'(m_axis_tdata[18:3]));
        if (m_axis_tdata[34:19] !== result_want.jitter)
          note_mismatch("jitter_mean", 32'(result_want.jitter), 32'(m_axis_tdata[34:19]));
        if (m_axis_tdata[50:35] !== result_want.avg)
          note_mismatch("avg_period", 32'(result_want.avg), 32'(m_axis_tdata[50:35]));
        if (m_axis_tdata[51] !== result_want.valid)
          note_mismatch("period_valid", 32'(result_want.valid), 32'(m_axis_tdata[51]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** pps_lock_detector_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= 32'd0;
    s_axis_tuser   <= KIND_PULSE;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= 32'd0;
    mismatch_count = 0;
    events_sent    = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    reset_lock_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_interval_bounds();
    test_lock_and_holdover();
    test_register_extremes();
    test_random_traffic(0, 0, 16'd100, 16'd5000, 16'd10, 16'd5000, 16'd17500);
    test_random_traffic(79, 0, 16'd900, 16'd1100, 16'd3, 16'd2000, 16'd4000);
    test_random_traffic(0, 79, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random_traffic(37, 37, 16'd1, 16'd300, 16'd0, 16'd100, 16'd200);
    drain();
    if (mismatch_count == 0) begin
      $display("** pps_lock_detector_core: PASSED **");
    end else begin
      $display("** pps_lock_detector_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pld_pkg.sv
sv/pld_ram.sv
sv/pld_walk.sv
sv/pld_div.sv
sv/pps_lock_detector_core.sv
tb/sv/pps_lock_detector_core_tb.sv
